// ===== design/mtcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcc_pkg
// Shared types and constants for the two-cache MOESI coherence unit.
// ----------------------------------------------------------------------------
package mtcc_pkg;

   localparam int BLOCK_ADDR_W = 10;
   localparam int REQ_DATA_W   = 16;
   localparam int REQ_USER_W   = 2;
   localparam int RSP_DATA_W   = 16;
   localparam int STATE_W      = 3;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef enum logic [STATE_W-1:0] {
      ST_I = 3'd0,
      ST_S = 3'd1,
      ST_E = 3'd2,
      ST_O = 3'd3,
      ST_M = 3'd4
   } state_type;

   typedef enum logic [1:0] {
      BUS_NONE  = 2'd0,
      BUS_READ  = 2'd1,
      BUS_INV   = 2'd2,
      BUS_RWITM = 2'd3
   } bus_type;

   typedef enum logic [1:0] {
      SRC_OWN   = 2'd0,
      SRC_OTHER = 2'd1,
      SRC_MEM   = 2'd2
   } src_type;

   // states of both copies as found, invalid where the tag misses
   typedef struct packed {
      logic      is_write;
      state_type my_state;
      state_type rem_state;
   } lookup_type;

   typedef struct packed {
      state_type rem_state;
      state_type my_state;
      logic      writeback;
      src_type   src;
      bus_type   bus_op;
      logic      hit;
   } result_type;

endpackage

// ===== design/mtcc_protocol.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcc_protocol
// MOESI transition logic: bus operation, data source, write-back and the
// next states of the requesting and the remote copy.
// ----------------------------------------------------------------------------
module mtcc_protocol
   import mtcc_pkg::*;
(
   input  lookup_type lookup,
   output result_type result
);

   logic rem_dirty;
   logic rem_clean;

   assign rem_dirty = (lookup.rem_state == ST_M) || (lookup.rem_state == ST_O);
   assign rem_clean = (lookup.rem_state == ST_E) || (lookup.rem_state == ST_S);

   always_comb begin
      result.hit       = (lookup.my_state != ST_I);
      result.bus_op    = BUS_NONE;
      result.src       = SRC_OWN;
      result.writeback = 1'b0;
      result.my_state  = lookup.my_state;
      result.rem_state = lookup.rem_state;
      priority if (!lookup.is_write) begin
         if (!result.hit) begin
            result.bus_op = BUS_READ;
            priority if (rem_dirty) begin
               result.rem_state = ST_O;
               result.my_state  = ST_S;
               result.src       = SRC_OTHER;
            end else if (rem_clean) begin
               result.rem_state = ST_S;
               result.my_state  = ST_S;
               result.src       = SRC_OTHER;
            end else begin
               result.my_state = ST_E;
               result.src      = SRC_MEM;
            end
         end
      end else if (result.hit) begin
         if ((lookup.my_state == ST_S) || (lookup.my_state == ST_O)) begin
            result.bus_op    = BUS_INV;
            result.rem_state = ST_I;
         end
         result.my_state = ST_M;
      end else begin
         result.bus_op    = BUS_RWITM;
         result.writeback = (lookup.rem_state == ST_M);
         result.src       = rem_dirty ? SRC_OTHER : SRC_MEM;
         result.rem_state = ST_I;
         result.my_state  = ST_M;
      end
   end

endmodule

// ===== design/moesi_two_cache_coherence_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moesi_two_cache_coherence_unit
// Tags and MOESI states of two direct-mapped caches in one line memory;
// each access is looked up in both caches, resolved and written back.
//
//   channel  | direction | tdata                            | tuser
//   req_     | in        | [9:0] block_address              | [0] cmd, [1] requester
//   rsp_     | out       | hit, bus_operation, data_source, | -
//            |           | memory_writeback, requester_state, remote_state
//
// up to one transfer per cycle while rsp_ is not stalled; a request transfer first
// loads the memory read register at the transfer edge, then is resolved and
// written back into the output register
// back-to-back accesses to one line take the written-back row by forwarding
// after reset a clearing pass over all LINES_PER_CACHE lines holds req_tready low
// a stalled rsp_ holds the item being resolved and then the request side
// LINES_PER_CACHE and MEMORY_BLOCKS are powers of two
// ----------------------------------------------------------------------------
module moesi_two_cache_coherence_unit
   import mtcc_pkg::*;
#(
   parameter int LINES_PER_CACHE = 32,
   parameter int MEMORY_BLOCKS   = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [9:0] block_address
   input  logic [REQ_USER_W-1:0] req_tuser,   // [0] cmd, [1] requester
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [0] hit, [2:1] bus_operation,
                                              // [4:3] data_source,
                                              // [5] memory_writeback,
                                              // [8:6] requester_state,
                                              // [11:9] remote_state
);

   localparam int IDX_W    = $clog2(LINES_PER_CACHE);
   localparam int MB_W     = $clog2(MEMORY_BLOCKS);
   localparam int ADDR_W   = (MB_W < BLOCK_ADDR_W) ? MB_W : BLOCK_ADDR_W;
   localparam int TAG_W    = (ADDR_W > IDX_W) ? (ADDR_W - IDX_W) : 1;
   localparam int ENT_W    = TAG_W + STATE_W;
   localparam logic [BLOCK_ADDR_W-1:0] ADDR_MASK =
      (MEMORY_BLOCKS >= (1 << BLOCK_ADDR_W)) ? {BLOCK_ADDR_W{1'b1}}
                                             : BLOCK_ADDR_W'(MEMORY_BLOCKS - 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES_PER_CACHE - 1);

   // line memory: one row per index, entry per cache = {tag, state}
   logic [1:0][ENT_W-1:0] line_mem [LINES_PER_CACHE];

   logic                    clr_busy_ff;
   logic [IDX_W-1:0]        clr_idx_ff;

   logic                    s1_valid_ff;
   logic                    s1_cmd_ff;
   logic                    s1_req_ff;
   logic [IDX_W-1:0]        s1_idx_ff;
   logic [TAG_W-1:0]        s1_tag_ff;
   logic                    byp_ff;
   logic                    byp_in;
   logic [1:0][ENT_W-1:0]   byp_row_ff;
   logic [1:0][ENT_W-1:0]   rd_row_ff;

   logic                    out_valid_ff;
   logic                    out_valid_in;
   result_type              out_ff;

   logic [BLOCK_ADDR_W-1:0] eff_addr;
   logic [IDX_W-1:0]        req_idx;
   logic [TAG_W-1:0]        req_tag;
   logic                    accept;
   logic                    s1_adv;
   logic                    item_wr;

   logic [1:0][ENT_W-1:0]   cur_row;
   logic [1:0][ENT_W-1:0]   new_row;
   logic [ENT_W-1:0]        my_ent;
   logic [ENT_W-1:0]        oth_ent;
   logic                    my_held;
   logic                    oth_held;
   lookup_type              lookup;
   result_type              result;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_idx;
   logic [1:0][ENT_W-1:0]   wr_row;

   // request decode
   assign eff_addr = req_tdata[BLOCK_ADDR_W-1:0] & ADDR_MASK;
   assign req_idx  = eff_addr[IDX_W-1:0];
   assign req_tag  = TAG_W'(eff_addr >> IDX_W);

   assign s1_adv     = !out_valid_ff || rsp_tready;
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;
   assign item_wr    = s1_valid_ff && s1_adv;
   assign byp_in     = item_wr && (s1_idx_ff == req_idx);

   // lookup in both caches
   assign cur_row  = byp_ff ? byp_row_ff : rd_row_ff;
   assign my_ent   = cur_row[s1_req_ff];
   assign oth_ent  = cur_row[~s1_req_ff];
   assign my_held  = (my_ent[STATE_W-1:0] >= STATE_W'(ST_S)) &&
                     (my_ent[STATE_W-1:0] <= STATE_W'(ST_M)) &&
                     (my_ent[ENT_W-1:STATE_W] == s1_tag_ff);
   assign oth_held = (oth_ent[STATE_W-1:0] >= STATE_W'(ST_S)) &&
                     (oth_ent[STATE_W-1:0] <= STATE_W'(ST_M)) &&
                     (oth_ent[ENT_W-1:STATE_W] == s1_tag_ff);

   assign lookup.is_write  = (s1_cmd_ff == CMD_WRITE);
   assign lookup.my_state  = my_held ? state_type'(my_ent[STATE_W-1:0]) : ST_I;
   assign lookup.rem_state = oth_held ? state_type'(oth_ent[STATE_W-1:0]) : ST_I;

   mtcc_protocol u_protocol (
      .lookup (lookup),
      .result (result)
   );

   always_comb begin
      new_row             = cur_row;
      new_row[s1_req_ff]  = {s1_tag_ff, STATE_W'(result.my_state)};
      if (oth_held) begin
         new_row[~s1_req_ff] = {oth_ent[ENT_W-1:STATE_W], STATE_W'(result.rem_state)};
      end
   end

   // write port: clearing pass or item write-back
   assign wr_en  = clr_busy_ff || item_wr;
   assign wr_idx = clr_busy_ff ? clr_idx_ff : s1_idx_ff;
   assign wr_row = clr_busy_ff ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_idx] <= wr_row;
      end
      if (accept) begin
         rd_row_ff <= line_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST_IDX) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (item_wr) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req_tuser[0];
         s1_req_ff  <= req_tuser[1];
         s1_idx_ff  <= req_idx;
         s1_tag_ff  <= req_tag;
         byp_ff     <= byp_in;
         byp_row_ff <= new_row;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      priority if (item_wr) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_wr) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_ff);

   // no request transfer while the line memory is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
      else $error("request taken during clearing pass");

   // a miss always goes on the bus
   a_miss_on_bus: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.hit) |-> (out_ff.bus_op != BUS_NONE))
      else $error("miss without bus operation");

   // write-back only with read-with-intent-to-modify
   a_wb_rwitm: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.writeback) |->
         (out_ff.bus_op == BUS_RWITM && out_ff.src == SRC_OTHER))
      else $error("write-back outside of RWITM");

   // a stalled result keeps its payload and the resolved item waits
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("result changed under stall");

endmodule
